### hw/rtl/sensor_frame_checksum_parser_core_macros.svh
// ----------------------------------------------------------------------------
// Sensor frame checksum parser - assertion macros
// Concurrent assertion shorthands clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SENSOR_FRAME_CHECKSUM_PARSER_CORE_MACROS_SVH
`define SENSOR_FRAME_CHECKSUM_PARSER_CORE_MACROS_SVH

// same-cycle implication
`define SFCP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfcp assertion failed");

// next-cycle implication
`define SFCP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfcp assertion failed");

`endif

### hw/rtl/sfcp_pkg.sv
// ----------------------------------------------------------------------------
// Sensor frame checksum parser - package
// Frame layout constants, phase type and the tracker status bundle.
// ----------------------------------------------------------------------------
package sfcp_pkg;

    localparam logic [7:0] SYNC_BYTE = 8'h55;
    localparam logic [7:0] HDR_B1    = 8'h0A;
    localparam logic [7:0] HDR_B2    = 8'h85;
    localparam logic [7:0] HDR_B3    = 8'h01;

    localparam logic [3:0] POS_FIRST   = 4'd1;
    localparam logic [3:0] POS_HDR1    = 4'd1;
    localparam logic [3:0] POS_HDR2    = 4'd2;
    localparam logic [3:0] POS_HDR3    = 4'd3;
    localparam logic [3:0] POS_COND_HI = 4'd4;
    localparam logic [3:0] POS_COND_LO = 4'd5;
    localparam logic [3:0] POS_TEMP_HI = 4'd6;
    localparam logic [3:0] POS_TEMP_LO = 4'd7;
    localparam logic [3:0] POS_LAST    = 4'd10;

    // x / 10 == (x * 52429) >> 19 for any 16-bit x
    localparam logic [15:0] RECIP_TEN = 16'd52429;
    localparam int          RECIP_SHIFT = 19;

    typedef enum logic
    {
        PH_HUNT,
        PH_COLLECT
    } phase_t;

    typedef struct packed
    {
        logic        last;
        logic        header_ok;
        logic [7:0]  sum;
        logic [15:0] temperature;
        logic [12:0] cond_quot;
    } frame_stat_t;

endpackage

### hw/rtl/sfcp_frame_track.sv
// ----------------------------------------------------------------------------
// Sensor frame checksum parser - frame tracker
// Sync hunt, byte position, running sum, header check and field capture.
// ----------------------------------------------------------------------------
module sfcp_frame_track
    import sfcp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        take,
    input  logic [7:0]  rx_byte,
    output frame_stat_t stat
);

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [3:0]  pos_reg;
    logic [3:0]  pos_next;
    logic [7:0]  sum_reg;
    logic [7:0]  sum_next;
    logic        hdr_reg;
    logic        hdr_next;
    logic [7:0]  cond_hi_reg;
    logic [7:0]  cond_hi_next;
    logic [15:0] temp_reg;
    logic [15:0] temp_next;
    logic [12:0] quot_reg;
    logic [12:0] quot_next;
    logic [31:0] prod;

    assign prod = 32'({cond_hi_reg, rx_byte}) * 32'(RECIP_TEN);

    always_comb
    begin
        phase_next   = phase_reg;
        pos_next     = pos_reg;
        sum_next     = sum_reg;
        hdr_next     = hdr_reg;
        cond_hi_next = cond_hi_reg;
        temp_next    = temp_reg;
        quot_next    = quot_reg;
        if (take)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == SYNC_BYTE)
                    begin
                        phase_next = PH_COLLECT;
                        pos_next   = POS_FIRST;
                        sum_next   = rx_byte;
                        hdr_next   = 1'b1;
                    end
                end
                PH_COLLECT:
                begin
                    sum_next = sum_reg + rx_byte;
                    pos_next = pos_reg + 4'd1;
                    case (pos_reg)
                        POS_HDR1:    hdr_next = hdr_reg & (rx_byte == HDR_B1);
                        POS_HDR2:    hdr_next = hdr_reg & (rx_byte == HDR_B2);
                        POS_HDR3:    hdr_next = hdr_reg & (rx_byte == HDR_B3);
                        POS_COND_HI: cond_hi_next = rx_byte;
                        POS_COND_LO: quot_next = prod[RECIP_SHIFT+12:RECIP_SHIFT];
                        POS_TEMP_HI: temp_next = {rx_byte, temp_reg[7:0]};
                        POS_TEMP_LO: temp_next = {temp_reg[15:8], rx_byte};
                        POS_LAST:
                        begin
                            phase_next = PH_HUNT;
                            pos_next   = 4'd0;
                        end
                        default: ;
                    endcase
                end
                default: phase_next = PH_HUNT;
            endcase
        end
    end

    always_comb
    begin
        stat.last        = (phase_reg == PH_COLLECT) && (pos_reg == POS_LAST);
        stat.header_ok   = hdr_reg;
        stat.sum         = sum_reg;
        stat.temperature = temp_reg;
        stat.cond_quot   = quot_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            pos_reg   <= 4'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg     <= sum_next;
        hdr_reg     <= hdr_next;
        cond_hi_reg <= cond_hi_next;
        temp_reg    <= temp_next;
        quot_reg    <= quot_next;
    end

endmodule

### hw/rtl/sensor_frame_checksum_parser_core.sv
// ----------------------------------------------------------------------------
// Sensor frame checksum parser - top level
// Frames 55 0A 85 01 sensor packets and reports checked, held readings.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle unless in_stall is high. Bytes are
// dropped until 0x55, which opens an 11-byte frame; on the eleventh byte
// one result word leaves with the header and checksum flags and the held
// temperature, conductivity and dissolved-solids values, refreshed only
// by a frame that passes both checks. A byte is accepted the cycle it is
// offered, but for a closing byte: the single output register is the
// only hold-off point, so that byte waits only while the previous result
// word is still stalled. The registered result word shows in the cycle
// after the closing byte is taken. Conductivity / 10 is done by a reciprocal multiply registered when byte 5 arrives.
module sensor_frame_checksum_parser_core
    import sfcp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        header_ok,
    output logic        checksum_ok,
    output logic [15:0] temperature_tenths,
    output logic [12:0] conductivity,
    output logic [11:0] dissolved_solids
);

`include "sensor_frame_checksum_parser_core_macros.svh"

    frame_stat_t stat;
    logic        take;
    logic        close;
    logic        sum_match;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        header_ok_reg;
    logic        checksum_ok_reg;
    logic [15:0] temp_reg;
    logic [15:0] temp_next;
    logic [12:0] cond_reg;
    logic [12:0] cond_next;
    logic [11:0] solids_reg;
    logic [11:0] solids_next;

    sfcp_frame_track u_track
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .rx_byte (rx_byte),
        .stat    (stat)
    );

    assign in_stall  = out_valid_reg && out_stall && stat.last;
    assign take      = in_valid && !in_stall;
    assign close     = take && stat.last;
    assign sum_match = stat.header_ok && (stat.sum == rx_byte);

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        temp_next      = temp_reg;
        cond_next      = cond_reg;
        solids_next    = solids_reg;
        if (close)
        begin
            out_valid_next = 1'b1;
            if (sum_match)
            begin
                temp_next   = stat.temperature;
                cond_next   = stat.cond_quot;
                solids_next = stat.cond_quot[12:1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            temp_reg      <= 16'd0;
            cond_reg      <= 13'd0;
            solids_reg    <= 12'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            temp_reg      <= temp_next;
            cond_reg      <= cond_next;
            solids_reg    <= solids_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (close)
        begin
            header_ok_reg   <= stat.header_ok;
            checksum_ok_reg <= sum_match;
        end
    end

    assign out_valid          = out_valid_reg;
    assign header_ok          = header_ok_reg;
    assign checksum_ok        = checksum_ok_reg;
    assign temperature_tenths = temp_reg;
    assign conductivity       = cond_reg;
    assign dissolved_solids   = solids_reg;

    `SFCP_ASSERT_IMP(a_stall_needs_pending, in_stall, out_valid_reg)
    `SFCP_ASSERT_NXT(a_close_gives_word, close, out_valid_reg)
    `SFCP_ASSERT_IMP(a_sum_implies_hdr, out_valid_reg && checksum_ok_reg, header_ok_reg)
    `SFCP_ASSERT_IMP(a_solids_half, 1'b1, solids_reg == cond_reg[12:1])

endmodule

### tb/tb_sensor_frame_checksum_parser_core.sv
// ----------------------------------------------------------------------------
// Sensor frame checksum parser - testbench
// Sends byte streams of sensor frames (good, bad header, bad checksum,
// truncated, with noise between them) with or without random idling on
// both sides, predicts every result word with an in-bench frame tracker
// and checks each word field by field in order of arrival.
// ----------------------------------------------------------------------------
module tb_sensor_frame_checksum_parser_core;
    import sfcp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_BYTES = 11;
    localparam int SUM_BYTES   = 10;

    typedef enum logic [1:0]
    {
        FR_GOOD,
        FR_BAD_SUM,
        FR_BAD_HDR
    } frame_kind_t;

    typedef struct packed
    {
        logic        header_ok;
        logic        checksum_ok;
        logic [15:0] temperature_tenths;
        logic [12:0] conductivity;
        logic [11:0] dissolved_solids;
    } reading_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        header_ok;
    logic        checksum_ok;
    logic [15:0] temperature_tenths;
    logic [12:0] conductivity;
    logic [11:0] dissolved_solids;

    // frame tracker state
    phase_t      trk_phase = PH_HUNT;
    logic [3:0]  trk_pos = '0;
    logic [7:0]  trk_frame [0:FRAME_BYTES-1];
    logic [15:0] trk_temperature = '0;
    logic [12:0] trk_conductivity = '0;
    logic [11:0] trk_solids = '0;

    reading_t    pending_readings [$];
    reading_t    want;
    int          mismatches = 0;
    int          bytes_taken = 0;
    bit          tx_idle_en = 1'b1;
    bit          rx_idle_en = 1'b1;
    int          hold_left = 0;
    int          stall_left = 0;

    sensor_frame_checksum_parser_core dut
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .rx_byte            (rx_byte),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .header_ok          (header_ok),
        .checksum_ok        (checksum_ok),
        .temperature_tenths (temperature_tenths),
        .conductivity       (conductivity),
        .dissolved_solids   (dissolved_solids)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("tb_sensor_frame_checksum_parser_core failed");
        $finish;
    end

    task automatic report_mismatch(input string what);
        if (mismatches < 50)
            $display("MISMATCH at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    function automatic void judge_frame();
        logic [7:0]  sum;
        logic [15:0] cond_raw;
        reading_t    r;
        sum = '0;
        for (int i = 0; i < SUM_BYTES; i++)
            sum += trk_frame[i];
        r.header_ok = (trk_frame[0] == SYNC_BYTE) && (trk_frame[1] == HDR_B1) &&
                      (trk_frame[2] == HDR_B2) && (trk_frame[3] == HDR_B3);
        r.checksum_ok = r.header_ok && (sum == trk_frame[SUM_BYTES]);
        if (r.checksum_ok)
        begin
            cond_raw         = {trk_frame[4], trk_frame[5]};
            trk_temperature  = {trk_frame[6], trk_frame[7]};
            trk_conductivity = 13'(cond_raw / 16'd10);
            trk_solids       = 12'(trk_conductivity / 13'd2);
        end
        r.temperature_tenths = trk_temperature;
        r.conductivity       = trk_conductivity;
        r.dissolved_solids   = trk_solids;
        pending_readings.push_back(r);
    endfunction

    function automatic void track_byte(input logic [7:0] b);
        if (trk_phase == PH_HUNT)
        begin
            if (b == SYNC_BYTE)
            begin
                trk_frame[0] = b;
                trk_pos      = 4'd1;
                trk_phase    = PH_COLLECT;
            end
        end
        else
        begin
            trk_frame[trk_pos] = b;
            trk_pos++;
            if (trk_pos == FRAME_BYTES)
            begin
                judge_frame();
                trk_phase = PH_HUNT;
                trk_pos   = '0;
            end
        end
    endfunction

    task automatic send_byte(input logic [7:0] b);
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        track_byte(b);
        bytes_taken++;
        if (tx_idle_en && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    task automatic send_frame(input frame_kind_t kind, input logic [15:0] cond_raw,
                              input logic [15:0] temp_raw, input int n_send);
        logic [7:0] fb [0:FRAME_BYTES-1];
        logic [7:0] sum;
        int         slot;
        fb[0] = SYNC_BYTE;
        fb[1] = HDR_B1;
        fb[2] = HDR_B2;
        fb[3] = HDR_B3;
        fb[4] = cond_raw[15:8];
        fb[5] = cond_raw[7:0];
        fb[6] = temp_raw[15:8];
        fb[7] = temp_raw[7:0];
        fb[8] = 8'($urandom);
        fb[9] = 8'($urandom);
        if (kind == FR_BAD_HDR)
        begin
            slot = $urandom_range(1, 3);
            fb[slot] ^= 8'($urandom_range(1, 255));
        end
        sum = '0;
        for (int i = 0; i < SUM_BYTES; i++)
            sum += fb[i];
        fb[SUM_BYTES] = (kind == FR_BAD_SUM) ? sum ^ 8'($urandom_range(1, 255)) : sum;
        for (int i = 0; i < n_send; i++)
            send_byte(fb[i]);
    endtask

    function automatic logic [15:0] pick_reading();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_random_frame();
        int n_noise;
        int pick;
        n_noise = $urandom_range(0, 3);
        repeat (n_noise) send_byte(8'($urandom));
        pick = $urandom_range(0, 9);
        if (pick < 7)
            send_frame(FR_GOOD, pick_reading(), pick_reading(), FRAME_BYTES);
        else if (pick == 7)
            send_frame(FR_BAD_SUM, pick_reading(), pick_reading(), FRAME_BYTES);
        else if (pick == 8)
            send_frame(FR_BAD_HDR, pick_reading(), pick_reading(), FRAME_BYTES);
        else
            send_frame(FR_GOOD, pick_reading(), pick_reading(),
                       $urandom_range(1, FRAME_BYTES - 1));
    endtask

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_readings.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed_frames();
        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(FR_GOOD, 16'hFFFF, 16'hFFFF, FRAME_BYTES);
        send_frame(FR_BAD_HDR, 16'h5555, 16'h0000, FRAME_BYTES);
        send_frame(FR_BAD_SUM, 16'h1234, 16'h8000, FRAME_BYTES);
    endtask

    task automatic test_random_traffic(input int n_bytes);
        int stop_at;
        stop_at = bytes_taken + n_bytes;
        while (bytes_taken < stop_at)
        begin
            tx_idle_en = ($urandom_range(0, 3) != 0);
            rx_idle_en = ($urandom_range(0, 3) != 0);
            send_random_frame();
        end
    endtask

    task automatic test_output_hold();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        hold_left  = 300;
        repeat (5) send_frame(FR_GOOD, pick_reading(), pick_reading(), FRAME_BYTES);
        wait_results_drained();
    endtask

    task automatic test_unthrottled_traffic(input int n_bytes);
        int stop_at;
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        stop_at = bytes_taken + n_bytes;
        while (bytes_taken < stop_at)
            send_random_frame();
        send_frame(FR_GOOD, pick_reading(), pick_reading(), FRAME_BYTES);
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else if (rx_idle_en && $urandom_range(0, 5) == 0)
            begin
                out_stall  <= 1'b1;
                stall_left = $urandom_range(1, 13) - 1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_readings.size() == 0)
                report_mismatch("result word with none expected");
            else
            begin
                want = pending_readings.pop_front();
                if (header_ok !== want.header_ok)
                    report_mismatch($sformatf("header_ok %b, want %b",
                                              header_ok, want.header_ok));
                if (checksum_ok !== want.checksum_ok)
                    report_mismatch($sformatf("checksum_ok %b, want %b",
                                              checksum_ok, want.checksum_ok));
                if (temperature_tenths !== want.temperature_tenths)
                    report_mismatch($sformatf("temperature_tenths %0d, want %0d",
                                              temperature_tenths, want.temperature_tenths));
                if (conductivity !== want.conductivity)
                    report_mismatch($sformatf("conductivity %0d, want %0d",
                                              conductivity, want.conductivity));
                if (dissolved_solids !== want.dissolved_solids)
                    report_mismatch($sformatf("dissolved_solids %0d, want %0d",
                                              dissolved_solids, want.dissolved_solids));
            end
        end
    end

    initial
    begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        rx_byte  <= 8'h00;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_frames();
        test_random_traffic(1300);
        wait_results_drained();
        test_output_hold();
        test_unthrottled_traffic(330);
        wait_results_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("tb_sensor_frame_checksum_parser_core passed");
        else
            $display("tb_sensor_frame_checksum_parser_core failed");
        $finish;
    end

endmodule
